>>> hdl/nsc_pkg.sv
// Shared types, character codes and helper functions for the NMEA sentence checker.
// No dependencies; nsc_parse and nmea_sentence_checker_core import this package.
`default_nettype none

package nsc_pkg;

  localparam int NumTypes = 5;
  localparam logic [2:0] BODY_SAT  = 3'd7;
  localparam logic [5:0] FIELD_SAT = 6'd63;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CHAR_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] HEX_TEN     = 8'h0A;

  // Sentence type codes
  localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
  localparam logic [2:0] TYPE_RMC     = 3'd1;
  localparam logic [2:0] TYPE_VTG     = 3'd2;
  localparam logic [2:0] TYPE_GGA     = 3'd3;
  localparam logic [2:0] TYPE_GSA     = 3'd4;
  localparam logic [2:0] TYPE_GLL     = 3'd5;

  // Checksum form codes
  localparam logic [1:0] FORM_NONE  = 2'd0;
  localparam logic [1:0] FORM_FULL  = 2'd1;
  localparam logic [1:0] FORM_SHORT = 2'd2;

  // Three type letters per candidate, candidate order RMC, VTG, GGA, GSA, GLL.
  localparam logic [7:0] TYPE_CHARS [NumTypes][3] = '{
    '{8'h52, 8'h4D, 8'h43},  // RMC
    '{8'h56, 8'h54, 8'h47},  // VTG
    '{8'h47, 8'h47, 8'h41},  // GGA
    '{8'h47, 8'h53, 8'h41},  // GSA
    '{8'h47, 8'h4C, 8'h4C}   // GLL
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] field_index;
    logic       is_separator;
    logic       sentence_done;
    logic [2:0] sentence_type;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [1:0] checksum_form;
    logic       checksum_ok;
  } result_t;

  // Unchecked hex digit conversion, modulo 256.
  function automatic logic [7:0] hex_value(input logic [7:0] d);
    if (d < CHAR_UPPER_A) begin
      return d - CHAR_ZERO;
    end
    return d + HEX_TEN - CHAR_UPPER_A;
  endfunction

  // Lowest surviving candidate wins.
  function automatic logic [2:0] pick_type(input logic [NumTypes-1:0] cand);
    logic [2:0] t;
    priority if (cand[0]) t = TYPE_RMC;
    else if (cand[1]) t = TYPE_VTG;
    else if (cand[2]) t = TYPE_GGA;
    else if (cand[3]) t = TYPE_GSA;
    else if (cand[4]) t = TYPE_GLL;
    else t = TYPE_UNKNOWN;
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nsc_in_if.sv
// Input channel: one sentence byte per transaction with a final-byte flag.
// Depends on nothing.
`default_nettype none

interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/nsc_out_if.sv
// Result channel: per-byte field tags plus sentence checksum and type report.
// Depends on nothing.
`default_nettype none

interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] field_index;
  logic       is_separator;
  logic       sentence_done;
  logic [2:0] sentence_type;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;
  logic [1:0] checksum_form;
  logic       checksum_ok;

  modport source (
    output valid, output field_index, output is_separator, output sentence_done,
    output sentence_type, output computed_checksum, output received_checksum,
    output checksum_form, output checksum_ok, input ready
  );
  modport sink (
    input valid, input field_index, input is_separator, input sentence_done,
    input sentence_type, input computed_checksum, input received_checksum,
    input checksum_form, input checksum_ok, output ready
  );
endinterface

`default_nettype wire

>>> hdl/nsc_parse.sv
// Sentence state and per-byte parse logic: checksum, hex digits, type, fields.
// Depends on nsc_pkg.
`default_nettype none

module nsc_parse
  import nsc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire in_item_t item,
  output result_t       result
);

  logic [2:0]          byte_position, byte_position_next;
  logic                leading_dollar, leading_dollar_next;
  logic [NumTypes-1:0] type_candidates, type_candidates_next;
  logic [7:0]          running_xor, running_xor_next;
  logic                star_seen, star_seen_next;
  logic [1:0]          digit_count, digit_count_next;
  logic [7:0]          received_value, received_value_next;
  logic [5:0]          field_counter, field_counter_next;

  logic       body;
  logic       sep;
  logic [1:0] col;
  logic [7:0] digit;
  logic [1:0] form;
  logic [7:0] recv;

  always_comb begin
    byte_position_next   = byte_position;
    leading_dollar_next  = leading_dollar;
    type_candidates_next = type_candidates;
    running_xor_next     = running_xor;
    star_seen_next       = star_seen;
    digit_count_next     = digit_count;
    received_value_next  = received_value;
    field_counter_next   = field_counter;

    body  = !(byte_position == 3'd0 && !leading_dollar && item.data_byte == CHAR_DOLLAR);
    col   = 2'(byte_position - 3'd2);
    digit = hex_value(item.data_byte);
    sep   = (item.data_byte == CHAR_COMMA);

    if (!body) begin
      leading_dollar_next = 1'b1;
    end else begin
      if (byte_position >= 3'd2 && byte_position <= 3'd4) begin
        for (int k = 0; k < NumTypes; k++) begin
          if (TYPE_CHARS[k][col] != item.data_byte) type_candidates_next[k] = 1'b0;
        end
      end
      if (byte_position < BODY_SAT) byte_position_next = byte_position + 3'd1;
    end

    if (!star_seen) begin
      if (item.data_byte == CHAR_STAR) star_seen_next = 1'b1;
      else if (body) running_xor_next = running_xor ^ item.data_byte;
    end else if (digit_count < 2'd2) begin
      if (digit_count == 2'd0) received_value_next = {digit[3:0], 4'h0};
      else received_value_next = received_value | digit;
      digit_count_next = digit_count + 2'd1;
    end

    if (sep && field_counter < FIELD_SAT) field_counter_next = field_counter + 6'd1;

    // Sentence-end report from the updated state
    if (!star_seen_next) form = FORM_NONE;
    else if (digit_count_next >= 2'd2) form = FORM_FULL;
    else form = FORM_SHORT;
    recv = (form == FORM_FULL) ? received_value_next : 8'h00;

    result.field_index       = field_counter;
    result.is_separator      = sep;
    result.sentence_done     = item.final_byte;
    result.computed_checksum = running_xor_next;
    result.sentence_type     = TYPE_UNKNOWN;
    result.received_checksum = 8'h00;
    result.checksum_form     = FORM_NONE;
    result.checksum_ok       = 1'b0;
    if (item.final_byte) begin
      if (byte_position_next >= 3'd5) result.sentence_type = pick_type(type_candidates_next);
      result.received_checksum = recv;
      result.checksum_form     = form;
      result.checksum_ok       = (form != FORM_SHORT) && (running_xor_next == recv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && item.final_byte)) begin
      byte_position   <= '0;
      leading_dollar  <= 1'b0;
      type_candidates <= '1;
      running_xor     <= '0;
      star_seen       <= 1'b0;
      digit_count     <= '0;
      received_value  <= '0;
      field_counter   <= '0;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      leading_dollar  <= leading_dollar_next;
      type_candidates <= type_candidates_next;
      running_xor     <= running_xor_next;
      star_seen       <= star_seen_next;
      digit_count     <= digit_count_next;
      received_value  <= received_value_next;
      field_counter   <= field_counter_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/nmea_sentence_checker_core.sv
// NMEA 0183 sentence checker: a byte transaction loads the input register; the parse
// logic then loads its result into the result register, which drives result_chan.
// Throughput one byte per cycle while result_chan is ready; the parse state updates
// once per byte in a single pass.
// Synchronous active-high reset empties both registers and returns the sentence
// state to its idle values; state also clears after every final byte.
// Depends on nsc_pkg, nsc_in_if, nsc_out_if and nsc_parse.
`default_nettype none

module nmea_sentence_checker_core
  import nsc_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  nsc_in_if.sink    char_chan,
  nsc_out_if.source result_chan
);

  // Input register stage
  logic     stage_valid;
  in_item_t stage_item;

  // Result register stage
  logic    res_valid;
  result_t res;
  result_t parse_result;

  logic res_free;
  logic advance;

  // Result register can load when empty or being drained this cycle.
  assign res_free = !res_valid || result_chan.ready;
  // Move the staged byte through the parser into the result register.
  assign advance  = stage_valid && res_free;
  // Take a new byte whenever the input register is empty or emptying.
  assign char_chan.ready = !stage_valid || advance;

  nsc_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .result  (parse_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (char_chan.ready) stage_valid <= char_chan.valid;
      if (res_free) res_valid <= stage_valid;
    end
  end

  // Payload registers: hold while stalled, no reset needed.
  always_ff @(posedge clk) begin
    if (char_chan.ready && char_chan.valid) begin
      stage_item.data_byte  <= char_chan.data_byte;
      stage_item.final_byte <= char_chan.final_byte;
    end
    if (advance) res <= parse_result;
  end

  assign result_chan.valid             = res_valid;
  assign result_chan.field_index       = res.field_index;
  assign result_chan.is_separator      = res.is_separator;
  assign result_chan.sentence_done     = res.sentence_done;
  assign result_chan.sentence_type     = res.sentence_type;
  assign result_chan.computed_checksum = res.computed_checksum;
  assign result_chan.received_checksum = res.received_checksum;
  assign result_chan.checksum_form     = res.checksum_form;
  assign result_chan.checksum_ok       = res.checksum_ok;

endmodule

`default_nettype wire
